FILE: rtl/core/i2c_master_transaction_sequencer_unit_assert.svh
// ----------------------------------------------------------------------------
// i2c sequencer assertion macros
// shared concurrent assertion forms, clocked on clk, quiet while in reset
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_UNIT_ASSERT_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_UNIT_ASSERT_SVH

// condition holds in the same cycle
`define I2CMTS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("i2c sequencer check failed");

// condition holds in the following cycle
`define I2CMTS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("i2c sequencer check failed");

`endif

FILE: rtl/core/i2cmts_pkg.sv
// ----------------------------------------------------------------------------
// i2c master transaction sequencer package
// transaction types, phase encoding, op codes and count width
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cmts_pkg;

	localparam int COUNT_BITS = 16;

	typedef logic [COUNT_BITS-1:0] count_t;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_IRQ   = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_WADDR = 3'd1,
		PH_RADDR = 3'd2,
		PH_TX    = 3'd3,
		PH_RX    = 3'd4,
		PH_RXEN  = 3'd5,
		PH_STOP  = 3'd6
	} phase_t;

	typedef struct packed {
		logic [1:0]  op;
		logic        nack;
		logic [7:0]  rx_data;
		logic [7:0]  tx_data;
		logic [15:0] length;
	} in_item_t;

	typedef struct packed {
		logic       accepted;
		logic       start_cond;
		logic       stop_cond;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       rx_enable;
		logic       ack_pulse;
		logic       ack_value;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic       busy_res;
		logic       error;
	} out_item_t;

	typedef struct packed {
		phase_t phase;
		count_t remaining;
		logic   addr_check;
		logic   busy;
		logic   error;
	} seq_state_t;

	// length cut or widened to the count width, zero taken as one
	function automatic count_t load_count(logic [15:0] len);
		logic [47:0] ext;
		count_t      cnt;
		ext = {32'd0, len};
		cnt = ext[COUNT_BITS-1:0];
		if (cnt == '0) begin
			cnt = count_t'(1);
		end
		return cnt;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/i2cmts_step.sv
// ----------------------------------------------------------------------------
// i2c sequencer step logic
// next state and result of one transaction from the current state
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cmts_step (
	input  var i2cmts_pkg::seq_state_t state_cur,
	input  var i2cmts_pkg::in_item_t   item,
	input  var logic [6:0]             slave_address,
	output i2cmts_pkg::seq_state_t     state_nxt,
	output i2cmts_pkg::out_item_t      result
);

	i2cmts_pkg::count_t rem_dec;
	logic               more;

	assign rem_dec = (state_cur.remaining != '0) ?
		state_cur.remaining - i2cmts_pkg::count_t'(1) : '0;
	assign more = (rem_dec != '0);

	// next state
	always_comb begin
		state_nxt = state_cur;
		unique case (item.op) inside
			i2cmts_pkg::OP_WRITE, i2cmts_pkg::OP_READ: begin
				if (!state_cur.busy) begin
					state_nxt.busy      = 1'b1;
					state_nxt.phase     = (item.op == i2cmts_pkg::OP_READ) ?
						i2cmts_pkg::PH_RADDR : i2cmts_pkg::PH_WADDR;
					state_nxt.remaining = i2cmts_pkg::load_count(item.length);
				end
			end
			i2cmts_pkg::OP_IRQ: begin
				if (state_cur.addr_check && item.nack) begin
					state_nxt.addr_check = 1'b0;
					state_nxt.error      = 1'b1;
					state_nxt.phase      = i2cmts_pkg::PH_IDLE;
				end else begin
					unique case (state_cur.phase)
						i2cmts_pkg::PH_WADDR: begin
							state_nxt.addr_check = 1'b1;
							state_nxt.phase      = i2cmts_pkg::PH_TX;
						end
						i2cmts_pkg::PH_RADDR: begin
							state_nxt.addr_check = 1'b1;
							state_nxt.phase      = i2cmts_pkg::PH_RXEN;
						end
						i2cmts_pkg::PH_TX: begin
							if (item.nack) begin
								state_nxt.phase = i2cmts_pkg::PH_IDLE;
							end else begin
								state_nxt.addr_check = 1'b0;
								state_nxt.remaining  = rem_dec;
								state_nxt.phase      = more ?
									i2cmts_pkg::PH_TX : i2cmts_pkg::PH_STOP;
							end
						end
						i2cmts_pkg::PH_RX: begin
							state_nxt.remaining = rem_dec;
							state_nxt.phase     = more ?
								i2cmts_pkg::PH_RXEN : i2cmts_pkg::PH_STOP;
						end
						i2cmts_pkg::PH_RXEN: begin
							state_nxt.addr_check = 1'b0;
							state_nxt.phase      = i2cmts_pkg::PH_RX;
						end
						i2cmts_pkg::PH_STOP: begin
							state_nxt.phase = i2cmts_pkg::PH_IDLE;
						end
						default: begin
							state_nxt.busy  = 1'b0;
							state_nxt.error = 1'b0;
							state_nxt.phase = i2cmts_pkg::PH_IDLE;
						end
					endcase
				end
			end
			default: begin
				state_nxt = state_cur;
			end
		endcase
	end

	// result fields
	always_comb begin
		result = '0;
		unique case (item.op) inside
			i2cmts_pkg::OP_WRITE, i2cmts_pkg::OP_READ: begin
				if (!state_cur.busy) begin
					result.accepted   = 1'b1;
					result.start_cond = 1'b1;
				end
			end
			i2cmts_pkg::OP_IRQ: begin
				if (state_cur.addr_check && item.nack) begin
					result.stop_cond = 1'b1;
				end else begin
					unique case (state_cur.phase)
						i2cmts_pkg::PH_WADDR: begin
							result.tx_valid = 1'b1;
							result.tx_byte  = {slave_address, 1'b0};
						end
						i2cmts_pkg::PH_RADDR: begin
							result.tx_valid = 1'b1;
							result.tx_byte  = {slave_address, 1'b1};
						end
						i2cmts_pkg::PH_TX: begin
							if (item.nack) begin
								result.stop_cond = 1'b1;
							end else begin
								result.tx_valid = 1'b1;
								result.tx_byte  = item.tx_data;
							end
						end
						i2cmts_pkg::PH_RX: begin
							result.rx_valid  = 1'b1;
							result.rx_byte   = item.rx_data;
							result.ack_pulse = 1'b1;
							result.ack_value = !more;
						end
						i2cmts_pkg::PH_RXEN: begin
							result.rx_enable = 1'b1;
						end
						i2cmts_pkg::PH_STOP: begin
							result.stop_cond = 1'b1;
						end
						default: begin
							result.stop_cond = 1'b0;
						end
					endcase
				end
			end
			default: begin
				result.accepted = 1'b0;
			end
		endcase
		result.busy_res = state_nxt.busy;
		result.error    = state_nxt.error;
	end

endmodule

`default_nettype wire

FILE: rtl/core/i2cmts_outreg.sv
// ----------------------------------------------------------------------------
// i2c sequencer result register
// holds one finished transaction until the downstream side takes it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cmts_outreg (
	input  var logic                  clk,
	input  var logic                  arst_n,
	input  var logic                  load,
	input  var i2cmts_pkg::out_item_t load_item,
	output logic                      free,
	output logic                      out_valid,
	input  var logic                  out_stall,
	output i2cmts_pkg::out_item_t     out_item
);

	logic                  vld_s2;
	i2cmts_pkg::out_item_t item_s2;

	// empty, or emptied at this edge
	assign free = !vld_s2 || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (free) begin
			vld_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			item_s2 <= load_item;
		end
	end

	assign out_valid = vld_s2;
	assign out_item  = item_s2;

endmodule

`default_nettype wire

FILE: rtl/core/i2c_master_transaction_sequencer_unit.sv
// ----------------------------------------------------------------------------
// i2c master transaction sequencer unit
// stages: input register, then result register; a result is offered from the
// result register once its transaction leaves the input register, until taken
// throughput: one transaction per cycle while out_stall is low
// reset: arst_n clears phase to idle, count, flags, address and both stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "i2c_master_transaction_sequencer_unit_assert.svh"

module i2c_master_transaction_sequencer_unit (
	input  var logic                  clk,
	input  var logic                  arst_n,
	// configuration write channel, slave address only
	input  var logic                  cfg_valid,
	output logic                      cfg_ready,
	input  var logic [6:0]            cfg_data,
	// input transactions
	input  var logic                  in_valid,
	output logic                      in_stall,
	input  var i2cmts_pkg::in_item_t  in_item,
	// result transactions
	output logic                      out_valid,
	input  var logic                  out_stall,
	output i2cmts_pkg::out_item_t     out_item
);

	logic [6:0]             slave_address_q;
	i2cmts_pkg::seq_state_t state_q;
	i2cmts_pkg::seq_state_t state_nxt;
	i2cmts_pkg::out_item_t  step_result;

	logic                   in_vld_s1;
	i2cmts_pkg::in_item_t   in_item_s1;
	logic                   out_free;
	logic                   advance;
	logic                   byte_phase;
	logic                   s1_start;

	// always taken; the user must write only while the block is idle, unchecked
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			slave_address_q <= cfg_data;
		end
	end

	// a held transaction moves on once the result register can take it
	assign advance  = in_vld_s1 && out_free;
	assign in_stall = in_vld_s1 && !out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			in_item_s1 <= in_item;
		end
	end

	// sequencer state, updated once per transaction that leaves stage one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase      <= i2cmts_pkg::PH_IDLE;
			state_q.remaining  <= '0;
			state_q.addr_check <= 1'b0;
			state_q.busy       <= 1'b0;
			state_q.error      <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	i2cmts_step u_step (
		.state_cur     (state_q),
		.item          (in_item_s1),
		.slave_address (slave_address_q),
		.state_nxt     (state_nxt),
		.result        (step_result)
	);

	// result register, parts the stall path from the state update
	i2cmts_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_vld_s1),
		.load_item (step_result),
		.free      (out_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	// phases that still owe bytes, and a start waiting in stage one
	assign byte_phase = (state_q.phase == i2cmts_pkg::PH_TX) ||
		(state_q.phase == i2cmts_pkg::PH_RX) || (state_q.phase == i2cmts_pkg::PH_RXEN);
	assign s1_start = (in_item_s1.op == i2cmts_pkg::OP_WRITE) ||
		(in_item_s1.op == i2cmts_pkg::OP_READ);

	// any active phase belongs to a transfer in progress
	`I2CMTS_ASSERT_SAME(a_phase_busy, state_q.phase != i2cmts_pkg::PH_IDLE, state_q.busy)

	// the address check only runs inside a transfer
	`I2CMTS_ASSERT_SAME(a_addr_busy, state_q.addr_check, state_q.busy)

	// byte phases always have at least one byte left
	`I2CMTS_ASSERT_SAME(a_count_live, byte_phase, state_q.remaining != '0)

	// a start taken while idle leaves the block busy
	`I2CMTS_ASSERT_NEXT(a_start_busy, advance && !state_q.busy && s1_start, state_q.busy)

endmodule

`default_nettype wire
